### hdl/csvfs_pkg.sv
// csvfs_pkg: types and constants shared by the csv field splitter modules
// no dependencies

`default_nettype none

package csvfs_pkg;

    // parse mode codes
    typedef enum logic [2:0] {
        MODE_VALUE   = 3'd0,
        MODE_QUOTED  = 3'd1,
        MODE_QUOTED2 = 3'd2,
        MODE_SKIPWS  = 3'd3,
        MODE_DISCARD = 3'd4
    } t_mode;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // one result word without its run_last flag
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
    } t_result;

    // queue entry: first result, plus a flag for a trailing empty-field result
    typedef struct packed {
        t_result first;
        logic    two;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam t_result RES_ROW_END = '{out_byte: 8'h00, byte_valid: 1'b0,
                                        field_end: 1'b1, row_end: 1'b1};

endpackage

`default_nettype wire

### hdl/csvfs_if.sv
// csvfs_in_if and csvfs_out_if: valid/ready channels of the csv field splitter
// no dependencies

`default_nettype none

interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       row_last;

    modport source (output valid, output in_byte, output row_last, input ready);
    modport sink   (input valid, input in_byte, input row_last, output ready);
endinterface

interface csvfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       row_end;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid,
                    output field_end, output row_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input field_end, input row_end, input run_last, output ready);
endinterface

`default_nettype wire

### hdl/csvfs_front.sv
// csvfs_front: accepts raw bytes, tracks the parse mode and classifies each byte
// depends on csvfs_pkg and csvfs_if

`default_nettype none

module csvfs_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    csvfs_in_if.sink                  i_in,
    input  wire csvfs_pkg::t_q_status i_q_status,
    output csvfs_pkg::t_q_wr          o_q_wr
);
    import csvfs_pkg::*;

    t_mode   r_mode, n_mode;
    t_mode   eff_mode, body_mode;
    t_result res0;
    logic    n0;
    logic    accept;
    logic    push;
    logic    two;
    logic    is_sp;

    function automatic logic f_is_space(input logic [7:0] b);
        f_is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_sp      = f_is_space(i_in.in_byte);

    always_comb begin
        // codes beyond the discard mode behave as plain value mode
        unique case (r_mode)
            MODE_QUOTED, MODE_QUOTED2, MODE_SKIPWS, MODE_DISCARD: eff_mode = r_mode;
            default: eff_mode = MODE_VALUE;
        endcase
        if (eff_mode == MODE_SKIPWS && !is_sp) begin
            body_mode = MODE_VALUE;
        end else begin
            body_mode = eff_mode;
        end

        res0   = '{out_byte: i_in.in_byte, byte_valid: 1'b1, field_end: 1'b0,
                   row_end: 1'b0};
        n0     = 1'b0;
        two    = 1'b0;
        n_mode = r_mode;

        priority if (eff_mode == MODE_DISCARD) begin
            n_mode = i_in.row_last ? MODE_VALUE : MODE_DISCARD;
        end else if (eff_mode == MODE_SKIPWS && is_sp) begin
            if (i_in.row_last) begin
                res0   = RES_ROW_END;
                n0     = 1'b1;
                n_mode = MODE_VALUE;
            end else begin
                n_mode = MODE_SKIPWS;
            end
        end else if (i_in.in_byte == CH_NUL) begin
            res0   = RES_ROW_END;
            n0     = 1'b1;
            n_mode = i_in.row_last ? MODE_VALUE : MODE_DISCARD;
        end else begin
            unique case (body_mode)
                MODE_QUOTED: begin
                    if (i_in.in_byte == CH_QUOTE) begin
                        n_mode = MODE_QUOTED2;
                    end else begin
                        n0     = 1'b1;
                        n_mode = MODE_QUOTED;
                    end
                end
                MODE_QUOTED2: begin
                    n0 = 1'b1;
                    if (i_in.in_byte == CH_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else if (i_in.in_byte == CH_COMMA) begin
                        res0.byte_valid = 1'b0;
                        res0.out_byte   = 8'h00;
                        res0.field_end  = 1'b1;
                        n_mode          = MODE_SKIPWS;
                    end else begin
                        n_mode = MODE_VALUE;
                    end
                end
                default: begin
                    if (i_in.in_byte == CH_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else if (i_in.in_byte == CH_COMMA) begin
                        n0              = 1'b1;
                        res0.byte_valid = 1'b0;
                        res0.out_byte   = 8'h00;
                        res0.field_end  = 1'b1;
                        n_mode          = MODE_SKIPWS;
                    end else begin
                        n0     = 1'b1;
                        n_mode = MODE_VALUE;
                    end
                end
            endcase
            if (i_in.row_last) begin
                // comma on the last byte adds an empty closing field
                if (n_mode == MODE_SKIPWS) begin
                    two = 1'b1;
                end else if (!n0) begin
                    res0 = RES_ROW_END;
                    n0   = 1'b1;
                end else begin
                    res0.field_end = 1'b1;
                    res0.row_end   = 1'b1;
                end
                n_mode = MODE_VALUE;
            end
        end
    end

    assign push           = accept && n0;
    assign o_q_wr.push    = push;
    assign o_q_wr.entry   = '{first: res0, two: two};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_VALUE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

### hdl/csvfs_fifo.sv
// csvfs_fifo: short register queue of classified entries between front and back
// depends on csvfs_pkg

`default_nettype none

module csvfs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire csvfs_pkg::t_q_wr   i_q_wr,
    input  wire logic               i_pop,
    output csvfs_pkg::t_entry       o_entry,
    output csvfs_pkg::t_q_status    o_status
);
    import csvfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_q_wr.push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/csvfs_back.sv
// csvfs_back: drains queue entries into the output register, one or two words each
// depends on csvfs_pkg and csvfs_if

`default_nettype none

module csvfs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire csvfs_pkg::t_entry    i_entry,
    input  wire csvfs_pkg::t_q_status i_q_status,
    output logic                      o_pop,
    csvfs_out_if.source               o_out
);
    import csvfs_pkg::*;

    t_result r_res;
    logic    r_run_last;
    logic    r_valid;
    logic    r_pending;
    logic    load;

    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && !r_pending && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
        end else if (load) begin
            priority if (r_pending) begin
                r_valid   <= 1'b1;
                r_pending <= 1'b0;
            end else if (!i_q_status.empty) begin
                r_valid   <= 1'b1;
                r_pending <= i_entry.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pending) begin
                r_res      <= RES_ROW_END;
                r_run_last <= 1'b1;
            end else begin
                r_res      <= i_entry.first;
                r_run_last <= !i_entry.two;
            end
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_res.out_byte;
    assign o_out.byte_valid = r_res.byte_valid;
    assign o_out.field_end  = r_res.field_end;
    assign o_out.row_end    = r_res.row_end;
    assign o_out.run_last   = r_run_last;

endmodule

`default_nettype wire

### hdl/csv_field_splitter_unit.sv
// csv_field_splitter_unit: top level of the streaming csv field splitter
// depends on csvfs_pkg, csvfs_if, csvfs_front, csvfs_fifo and csvfs_back
//
// usage
//   i_in carries one raw row byte per word (in_byte) with row_last on the final
//   byte of a row. o_out carries result words: an unquoted field byte
//   (byte_valid), field_end and row_end marks, and run_last on the last word
//   caused by one input byte. a byte gives zero, one or two result words.
//   quotes are stripped, a doubled quote inside quotes gives one quote, a comma
//   outside quotes ends the field, white space after a comma is skipped, and a
//   zero byte ends the row and drops the rest of it.
// timing
//   one input byte is taken every cycle while the queue has room. a result word
//   goes through the queue and then the output register. a byte with two result
//   words takes the output register for both; the DEPTH-entry queue between the
//   classifier and the output stage absorbs that, so with o_out.ready high the
//   sustained rate is one byte per cycle unless two-word bytes come back to back.
// reset and stall
//   reset empties the queue and output register and puts the parser in plain
//   value mode. while o_out.ready is low the output word holds, the queue fills
//   and i_in.ready drops once it is full.

`default_nettype none

module csv_field_splitter_unit #(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    csvfs_in_if.sink     i_in,
    csvfs_out_if.source  o_out
);
    import csvfs_pkg::*;

    // front to queue
    t_q_wr     q_wr;
    // queue to back
    t_q_status q_status;
    t_entry    q_entry;
    logic      q_pop;

    // classifier and parse mode register
    csvfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_q_wr     (q_wr)
    );

    // decoupling queue
    csvfs_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (q_wr),
        .i_pop    (q_pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    // output stage, splits two-word entries
    csvfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (q_entry),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

    // the front never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr.push |-> !q_status.full)
        else $error("push into full queue");

    // row end always closes the field too
    a_row_end_field_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.row_end || o_out.field_end))
        else $error("row_end without field_end");

    // non-field words carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |-> (o_out.out_byte == 8'h00))
        else $error("non-field word with non-zero byte");

    // the second word of a byte follows straight after the first
    a_second_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.run_last) |=>
            (o_out.valid && o_out.run_last && o_out.row_end))
        else $error("second word missing after first");

    // a taken queue entry only leaves when the output stage can load
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!q_status.empty && (!o_out.valid || o_out.ready)))
        else $error("pop without room or data");

endmodule

`default_nettype wire

### tb/csv_field_splitter_unit_test.sv
// csv_field_splitter_unit_test: self-checking bench for the csv field splitter
// depends on csvfs_pkg, csvfs_if and the csv_field_splitter_unit rtl

`default_nettype none

module csv_field_splitter_unit_test;

    import csvfs_pkg::*;

    localparam int TARGET_BYTES = 1300;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_CAP    = 40;

    typedef logic [7:0] byte_q_t[$];

    // one result word as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
        logic       run_last;
    } result_word_t;

    // tracks the parse mode and holds the words that are still to come out
    class split_scoreboard;
        t_mode        tracked_mode;
        result_word_t pending_words[$];
        int           errors;
        int           live_bytes;
        int           rows_seen;
        int           words_seen;

        function new();
            tracked_mode = MODE_VALUE;
            errors       = 0;
            live_bytes   = 0;
            rows_seen    = 0;
            words_seen   = 0;
        endfunction

        function logic is_blank(input logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function result_word_t make_word(input logic [7:0] b, input logic v,
                                         input logic fe, input logic re);
            result_word_t w;
            w.out_byte   = b;
            w.byte_valid = v;
            w.field_end  = fe;
            w.row_end    = re;
            w.run_last   = 1'b0;
            return w;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch: %s", msg);
        endtask

        // work out the words caused by one accepted byte
        function void note_byte(input logic [7:0] b, input logic row_last);
            t_mode        m;
            result_word_t res[2];
            int           n;
            m = tracked_mode;
            n = 0;
            if (row_last)
                rows_seen++;
            if (m == MODE_DISCARD) begin
                if (row_last)
                    tracked_mode = MODE_VALUE;
                return;
            end
            live_bytes++;
            if (m == MODE_SKIPWS) begin
                if (is_blank(b)) begin
                    if (row_last) begin
                        res[0] = make_word(CH_NUL, 1'b0, 1'b1, 1'b1);
                        res[0].run_last = 1'b1;
                        pending_words.push_back(res[0]);
                        tracked_mode = MODE_VALUE;
                    end
                    return;
                end
                m = MODE_VALUE;
            end
            if (b == CH_NUL) begin
                res[0] = make_word(CH_NUL, 1'b0, 1'b1, 1'b1);
                res[0].run_last = 1'b1;
                pending_words.push_back(res[0]);
                tracked_mode = row_last ? MODE_VALUE : MODE_DISCARD;
                return;
            end
            case (m)
                MODE_QUOTED: begin
                    if (b == CH_QUOTE)
                        m = MODE_QUOTED2;
                    else
                        res[n++] = make_word(b, 1'b1, 1'b0, 1'b0);
                end
                MODE_QUOTED2: begin
                    if (b == CH_QUOTE) begin
                        res[n++] = make_word(CH_QUOTE, 1'b1, 1'b0, 1'b0);
                        m = MODE_QUOTED;
                    end else if (b == CH_COMMA) begin
                        res[n++] = make_word(CH_NUL, 1'b0, 1'b1, 1'b0);
                        m = MODE_SKIPWS;
                    end else begin
                        res[n++] = make_word(b, 1'b1, 1'b0, 1'b0);
                        m = MODE_VALUE;
                    end
                end
                default: begin
                    if (b == CH_QUOTE) begin
                        m = MODE_QUOTED;
                    end else if (b == CH_COMMA) begin
                        res[n++] = make_word(CH_NUL, 1'b0, 1'b1, 1'b0);
                        m = MODE_SKIPWS;
                    end else begin
                        res[n++] = make_word(b, 1'b1, 1'b0, 1'b0);
                    end
                end
            endcase
            if (row_last) begin
                if (m == MODE_SKIPWS || n == 0) begin
                    res[n++] = make_word(CH_NUL, 1'b0, 1'b1, 1'b1);
                end else begin
                    res[n-1].field_end = 1'b1;
                    res[n-1].row_end   = 1'b1;
                end
                m = MODE_VALUE;
            end
            tracked_mode = m;
            for (int i = 0; i < n; i++) begin
                res[i].run_last = (i == n - 1);
                pending_words.push_back(res[i]);
            end
        endfunction

        // compare one accepted output word with the oldest expected one
        task check_word(input result_word_t got);
            result_word_t want;
            logic         bad;
            words_seen++;
            if (pending_words.size() == 0) begin
                report($sformatf("word %0d arrived with nothing expected: %h",
                                 words_seen, got));
                return;
            end
            want = pending_words.pop_front();
            bad  = 1'b0;
            if (got.out_byte   !== want.out_byte)   bad = 1'b1;
            if (got.byte_valid !== want.byte_valid) bad = 1'b1;
            if (got.field_end  !== want.field_end)  bad = 1'b1;
            if (got.row_end    !== want.row_end)    bad = 1'b1;
            if (got.run_last   !== want.run_last)   bad = 1'b1;
            if (bad)
                report($sformatf(
                    "word %0d got byte %h v%b fe%b re%b rl%b, want %h v%b fe%b re%b rl%b",
                    words_seen, got.out_byte, got.byte_valid, got.field_end,
                    got.row_end, got.run_last, want.out_byte, want.byte_valid,
                    want.field_end, want.row_end, want.run_last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    csvfs_in_if  in_ch ();
    csvfs_out_if out_ch ();

    csv_field_splitter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    split_scoreboard split_sb = new();

    // shared state: the sender's calm flag, the receiver's hold request and the watchdog count
    logic sender_calm  = 1'b0;
    logic hold_request = 1'b0;
    int   cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] blank_byte();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return 8'h20;
        return 8'h08 + sel[7:0];
    endfunction

    // field content outside quotes: anything but comma, quote and zero
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h7E))
                                     : 8'($urandom_range(1, 255));
        end while (c == CH_COMMA || c == CH_QUOTE);
        return c;
    endfunction

    // raw bytes leaning towards the characters the parser reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return CH_COMMA;
            1:       return CH_QUOTE;
            2:       return blank_byte();
            3:       return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed rows, some with a zero byte, the rest pure noise
    function automatic byte_q_t make_row();
        byte_q_t    row;
        int         nf;
        logic [7:0] c;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 8)) row.push_back(noise_byte());
            return row;
        end
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
                row.push_back(CH_COMMA);
                repeat ($urandom_range(0, 2)) row.push_back(blank_byte());
            end
            case ($urandom_range(0, 3))
                0: ;
                1, 2: repeat ($urandom_range(1, 4)) row.push_back(plain_byte());
                default: begin
                    row.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 4))
                            0:       c = CH_QUOTE;
                            1:       c = CH_COMMA;
                            default: c = 8'($urandom_range(1, 255));
                        endcase
                        row.push_back(c);
                        // a quote inside quotes is written doubled
                        if (c == CH_QUOTE)
                            row.push_back(CH_QUOTE);
                    end
                    row.push_back(CH_QUOTE);
                end
            endcase
        end
        if (row.size() == 0)
            row.push_back(plain_byte());
        if ($urandom_range(0, 9) == 0)
            row.insert($urandom_range(0, row.size() - 1), CH_NUL);
        return row;
    endfunction

    // offer one word and wait for the handshake
    task automatic send_byte(input logic [7:0] b, input logic row_last);
        int gap;
        gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.row_last <= row_last;
        do @(posedge i_clk); while (!in_ch.ready);
        split_sb.note_byte(b, row_last);
    endtask

    task automatic send_row(input byte_q_t row);
        for (int i = 0; i < row.size(); i++)
            send_byte(row[i], i == row.size() - 1);
    endtask

    // receiver: random stalls in phases, plus one long hold on request
    initial begin
        int   stall_left;
        int   phase_left;
        logic recv_calm;
        result_word_t got;
        stall_left = 0;
        phase_left = 0;
        recv_calm  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.out_byte   = out_ch.out_byte;
                got.byte_valid = out_ch.byte_valid;
                got.field_end  = out_ch.field_end;
                got.row_end    = out_ch.row_end;
                got.run_last   = out_ch.run_last;
                split_sb.check_word(got);
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                recv_calm  = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
                stall_left   = gap_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on the whole run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic hold_done;
        hold_done = 1'b0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= CH_NUL;
        in_ch.row_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        // quoted field with a high byte and a doubled quote, closed before a comma,
        // then a skipped space and a plain byte that ends the row
        send_row('{CH_QUOTE, 8'hFF, CH_QUOTE, CH_QUOTE, 8'h79, CH_QUOTE,
                   CH_COMMA, 8'h20, 8'h7F});
        // comma on the last byte gives a trailing empty field
        send_row('{8'h71, CH_COMMA});
        // white space after a comma running into the end of the row
        send_row('{8'h70, CH_COMMA, 8'h20, 8'h09});
        // zero byte while skipping white space, the rest of the row dropped
        send_row('{8'h61, CH_COMMA, 8'h0D, CH_NUL, 8'h7A});
        // zero byte that is itself the last byte
        send_row('{CH_NUL});
        // lone quote on the last byte: nothing emitted but the row end
        send_row('{CH_QUOTE});
        // plain byte straight after a closing quote
        send_row('{CH_QUOTE, 8'h61, CH_QUOTE, 8'h80});

        // random rows
        while (split_sb.live_bytes < TARGET_BYTES) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && split_sb.live_bytes >= 500) begin
                // keep offering while the output is held so the input backs up
                hold_request = 1'b1;
                hold_done    = 1'b1;
                sender_calm  = 1'b1;
            end
            send_row(make_row());
        end
        in_ch.valid <= 1'b0;

        while (split_sb.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (split_sb.pending_words.size() != 0)
            split_sb.report($sformatf("%0d expected words never arrived",
                                      split_sb.pending_words.size()));

        $display("run covered %0d rows, %0d parsed bytes and %0d result words",
                 split_sb.rows_seen, split_sb.live_bytes, split_sb.words_seen);
        $display("with random stalls on both sides, one long output hold, %0d mismatches",
                 split_sb.errors);
        if (split_sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/csvfs_pkg.sv
hdl/csvfs_if.sv
hdl/csvfs_front.sv
hdl/csvfs_fifo.sv
hdl/csvfs_back.sv
hdl/csv_field_splitter_unit.sv
tb/csv_field_splitter_unit_test.sv
